@@ design/rph_pkg.sv @@
package rph_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ANG,
        S_Z2,
        S_T1,
        S_T2,
        S_SN,
        S_P1,
        S_P2,
        S_VX,
        S_EMUL,
        S_ECMP,
        S_ADV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic wr;
        logic load;
        logic shift;
    } t_cell_ctl;

    localparam int DIST_W   = 16;
    localparam int COORD_W  = 28;
    localparam int DIV_BITS = 17;
    localparam int DIST_ONE = 16384;
    localparam int QUARTER  = 16384;
    localparam int SIN_A    = 25736;
    localparam int SIN_B    = 10512;
    localparam int SIN_C    = 1160;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [2:0] REG_MIN_X    = 3'd0;
    localparam logic [2:0] REG_MIN_Y    = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_SIDES    = 3'd4;
    localparam logic [2:0] REG_START    = 3'd5;
    localparam logic [2:0] REG_USE_DIST = 3'd6;

endpackage

@@ design/regular_polygon_hit_test.sv @@
// Regular polygon hit test by the even-odd crossing rule.
// Input stream: s_axis_tuser carries op (0 loads a distance, 1 tests a point);
// s_axis_tdata carries slot, distance, point_x, point_y. A load writes one
// per-vertex distance cell and gives no result; a test gives one transaction
// on the output stream with the inside flag in bit 0 of m_axis_tdata.
// Geometry registers must be written through the APB port only while the
// block idles; the block itself does not enforce this. A test first divides
// a turn by the side count in a serial divider, then walks the vertices one
// at a time: each vertex takes a cosine pass and a sine pass on the shared
// sine polynomial and scale multipliers, a step of the distance chain and an
// edge crossing compare. Items are taken one at a time; s_axis_tready is high
// only while idle. The result sits in an output register; while the receiver
// stalls the next item can still be accepted, and a test only finishes once
// the register is free. Reset restores the register defaults and empties the
// output register; distance cells hold nothing defined until written.
module regular_polygon_hit_test
    import rph_pkg::*;
#(
    parameter int MAX_SIDES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // slot[3:0], distance[19:4], point_x[43:20],
                                       // point_y[67:44], zero fill
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // inside_res, zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(MAX_SIDES + 1);
    localparam int IW = $clog2(MAX_SIDES);

    t_state r_state, n_state;

    logic [23:0] r_min_x, r_min_y;
    logic [22:0] r_width, r_height;
    logic [4:0]  r_sides;
    logic [15:0] r_start;
    logic        r_use_dist;

    logic [SW-1:0]         r_n;
    logic [22:0]           r_m;
    logic [COORD_W-1:0]    r_cx, r_cy, r_px, r_py;
    logic [4:0]            r_dcnt;
    logic [SW-1:0]         r_rem;
    logic [DIV_BITS-1:0]   r_quo;
    logic [DIV_BITS-1:0]   r_acc;
    logic [SW-1:0]         r_accr;
    logic [IW-1:0]         r_i;
    logic                  r_is_sin;
    logic [14:0]           r_z, r_z2, r_t;
    logic                  r_neg;
    logic signed [16:0]    r_s;
    logic signed [31:0]    r_p1;
    logic signed [55:0]    r_p2;
    logic signed [COORD_W-1:0] r_xi, r_yi, r_xj, r_yj, r_x0, r_y0;
    logic                  r_close;
    logic signed [57:0]    r_lhs, r_rhs;
    logic                  r_cond, r_dypos, r_odd;
    logic                  r_ovalid, r_oinside;

    logic accept, cfg_wr, fin_ok, div_done, is_last, div_ge, adv_ge;
    logic [SW:0] div_tmp, adv_sum;
    t_cell_ctl cell_ctl;
    logic [DIST_W-1:0] w_pass [MAX_SIDES];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x    <= '0;
            r_min_y    <= '0;
            r_width    <= 23'd25600;
            r_height   <= 23'd25600;
            r_sides    <= 5'd3;
            r_start    <= '0;
            r_use_dist <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_MIN_X:    r_min_x    <= pwdata[23:0];
                REG_MIN_Y:    r_min_y    <= pwdata[23:0];
                REG_WIDTH:    r_width    <= pwdata[22:0];
                REG_HEIGHT:   r_height   <= pwdata[22:0];
                REG_SIDES:    r_sides    <= pwdata[4:0];
                REG_START:    r_start    <= pwdata[15:0];
                REG_USE_DIST: r_use_dist <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_MIN_X:    prdata = {8'b0, r_min_x};
            REG_MIN_Y:    prdata = {8'b0, r_min_y};
            REG_WIDTH:    prdata = {9'b0, r_width};
            REG_HEIGHT:   prdata = {9'b0, r_height};
            REG_SIDES:    prdata = {27'b0, r_sides};
            REG_START:    prdata = {16'b0, r_start};
            REG_USE_DIST: prdata = {31'b0, r_use_dist};
            default:      prdata = '0;
        endcase
    end

    // ---------------- distance chain ----------------
    for (genvar k = 0; k < MAX_SIDES; k++) begin : g_cell
        logic [DIST_W-1:0] w_next;
        if (k == MAX_SIDES - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_pass[k+1];
        end
        rph_cell #(.INDEX(k)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_slot  (s_axis_tdata[3:0]),
            .i_wdata (s_axis_tdata[19:4]),
            .i_next  (w_next),
            .o_pass  (w_pass[k])
        );
    end

    // ---------------- combinational helpers ----------------
    logic [SW-1:0]  sides_sat;
    logic [22:0]    m_min;
    logic signed [25:0] cx_sum, cy_sum;
    logic [15:0]    ang;
    logic [29:0]    z_sq, t_z2, z_t;
    logic [25:0]    c_z2;
    logic [16:0]    s_mag;
    logic signed [16:0] d_sel;
    logic signed [33:0] p1_full;
    logic signed [55:0] p2_full, p2_rnd;
    logic signed [COORD_W-1:0] off, coord;
    logic signed [COORD_W:0] e_dy, e_a, e_b, e_c;
    logic signed [57:0] lhs_full, rhs_full;
    logic e_cond;

    always_comb begin
        if (r_sides < 5'd3) begin
            sides_sat = SW'(3);
        end else if (32'(r_sides) > MAX_SIDES) begin
            sides_sat = SW'(MAX_SIDES);
        end else begin
            sides_sat = SW'(r_sides);
        end
    end

    assign m_min  = (r_width < r_height) ? r_width : r_height;
    assign cx_sum = $signed({r_min_x[23], r_min_x, 1'b0}) + $signed({3'b000, m_min});
    assign cy_sum = $signed({r_min_y[23], r_min_y, 1'b0}) + $signed({3'b000, m_min});

    assign div_tmp  = {r_rem, (r_dcnt == 5'd0)};
    assign div_ge   = div_tmp >= {1'b0, r_n};
    assign div_done = r_dcnt == 5'(DIV_BITS - 1);
    assign adv_sum  = {1'b0, r_accr} + {1'b0, r_rem};
    assign adv_ge   = adv_sum >= {1'b0, r_n};
    assign is_last  = SW'(r_i) == (r_n - SW'(1));

    // cosine pass is the sine a quarter turn on
    assign ang   = r_start + r_acc[15:0] + (r_is_sin ? 16'd0 : 16'(QUARTER));
    assign z_sq  = 30'(r_z) * 30'(r_z);
    assign c_z2  = 26'(SIN_C) * 26'(r_z2);
    assign t_z2  = 30'(r_t) * 30'(r_z2);
    assign z_t   = 30'(r_z) * 30'(r_t);
    assign s_mag = 17'(z_t >> 14);
    assign d_sel = r_use_dist ? $signed({1'b0, w_pass[0]}) : 17'sd16384;
    assign p1_full = d_sel * r_s;
    assign p2_full = $signed({1'b0, r_m}) * r_p1;
    assign p2_rnd  = r_p2 + 56'sd134217728;
    assign off     = p2_rnd[55:28];
    assign coord   = (r_is_sin ? $signed(r_cy) : $signed(r_cx)) + off;

    assign e_dy = $signed({r_yj[COORD_W-1], r_yj}) - $signed({r_yi[COORD_W-1], r_yi});
    assign e_a  = $signed({r_py[COORD_W-1], r_py}) - $signed({r_yi[COORD_W-1], r_yi});
    assign e_b  = $signed({r_xj[COORD_W-1], r_xj}) - $signed({r_xi[COORD_W-1], r_xi});
    assign e_c  = $signed({r_px[COORD_W-1], r_px}) - $signed({r_xi[COORD_W-1], r_xi});
    assign lhs_full = e_a * e_b;
    assign rhs_full = e_c * e_dy;
    assign e_cond = ((r_yi < $signed(r_py) && r_yj >= $signed(r_py)) ||
                     (r_yj < $signed(r_py) && r_yi >= $signed(r_py))) &&
                    (r_xi <= $signed(r_px) || r_xj <= $signed(r_px));

    // ---------------- sequencer ----------------
    assign accept = s_axis_tvalid && s_axis_tready;
    assign fin_ok = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && s_axis_tuser == OP_TEST) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_ANG;
            S_ANG:  n_state = S_Z2;
            S_Z2:   n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_SN;
            S_SN:   n_state = S_P1;
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_VX;
            S_VX: begin
                if (!r_is_sin) begin
                    n_state = S_ANG;
                end else if (r_i == '0) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_EMUL;
                end
            end
            S_EMUL: n_state = S_ECMP;
            S_ECMP: n_state = r_close ? S_FIN : S_ADV;
            S_ADV:  n_state = is_last ? S_EMUL : S_ANG;
            S_FIN:  if (fin_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready  = r_state == S_IDLE;
        cell_ctl.wr    = accept && s_axis_tuser == OP_LOAD;
        cell_ctl.load  = accept && s_axis_tuser == OP_TEST;
        cell_ctl.shift = r_state == S_ADV;
        m_axis_tvalid  = r_ovalid;
        m_axis_tdata   = {7'b0, r_oinside};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && fin_ok) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n      <= sides_sat;
                r_m      <= m_min;
                r_cx     <= COORD_W'(cx_sum);
                r_cy     <= COORD_W'(cy_sum);
                r_px     <= {{3{s_axis_tdata[43]}}, s_axis_tdata[43:20], 1'b0};
                r_py     <= {{3{s_axis_tdata[67]}}, s_axis_tdata[67:44], 1'b0};
                r_dcnt   <= '0;
                r_rem    <= '0;
                r_quo    <= '0;
                r_acc    <= '0;
                r_accr   <= '0;
                r_i      <= '0;
                r_is_sin <= 1'b0;
                r_close  <= 1'b0;
                r_odd    <= 1'b0;
            end
            S_DIV: begin
                // one quotient bit a cycle of a full turn over the side count
                r_dcnt <= r_dcnt + 5'd1;
                r_rem  <= div_ge ? SW'(div_tmp - {1'b0, r_n}) : SW'(div_tmp);
                r_quo  <= {r_quo[DIV_BITS-2:0], div_ge};
            end
            S_ANG: begin
                r_z   <= ang[14] ? 15'(QUARTER) - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
                r_neg <= ang[15];
            end
            S_Z2: r_z2 <= 15'(z_sq >> 14);
            S_T1: r_t  <= 15'(SIN_B) - 15'(c_z2 >> 14);
            S_T2: r_t  <= 15'(SIN_A) - 15'(t_z2 >> 14);
            S_SN: r_s  <= r_neg ? -$signed(s_mag) : $signed(s_mag);
            S_P1: r_p1 <= 32'(p1_full);
            S_P2: r_p2 <= p2_full;
            S_VX: begin
                if (!r_is_sin) begin
                    r_xi     <= coord;
                    r_is_sin <= 1'b1;
                end else begin
                    r_yi     <= coord;
                    r_is_sin <= 1'b0;
                    if (r_i == '0) begin
                        r_x0 <= r_xi;
                        r_y0 <= coord;
                        r_xj <= r_xi;
                        r_yj <= coord;
                    end
                end
            end
            S_EMUL: begin
                r_lhs   <= lhs_full;
                r_rhs   <= rhs_full;
                r_cond  <= e_cond;
                r_dypos <= e_dy > 0;
            end
            S_ECMP: begin
                if (r_cond && (r_dypos ? (r_lhs < r_rhs) : (r_lhs > r_rhs))) begin
                    r_odd <= !r_odd;
                end
                r_xj <= r_xi;
                r_yj <= r_yi;
            end
            S_ADV: begin
                r_i    <= r_i + IW'(1);
                r_acc  <= r_acc + r_quo + DIV_BITS'(adv_ge);
                r_accr <= adv_ge ? SW'(adv_sum - {1'b0, r_n}) : SW'(adv_sum);
                // closing edge runs from the last vertex back to the first
                if (is_last) begin
                    r_xi    <= r_x0;
                    r_yi    <= r_y0;
                    r_close <= 1'b1;
                end
            end
            S_FIN: begin
                if (fin_ok) begin
                    r_oinside <= r_odd;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ design/rph_cell.sv @@
module rph_cell
    import rph_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [3:0]        i_slot,
    input  logic [DIST_W-1:0] i_wdata,
    input  logic [DIST_W-1:0] i_next,
    output logic [DIST_W-1:0] o_pass
);

    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] r_pass;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (32'(i_slot) == INDEX)) begin
            r_dist <= i_wdata;
        end
        // a query snapshots the stored distances, then walks them towards cell zero
        if (i_ctl.load) begin
            r_pass <= r_dist;
        end else if (i_ctl.shift) begin
            r_pass <= i_next;
        end
    end

    assign o_pass = r_pass;

endmodule

@@ bench/regular_polygon_hit_test_tb.sv @@
module regular_polygon_hit_test_tb
    import rph_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // slot, distance, point_x, point_y, zero fill
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // inside_res, zero fill
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    regular_polygon_hit_test u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the geometry registers and the distance cells
    logic signed [23:0] min_x = '0, min_y = '0;
    logic [22:0] rect_w = 23'd25600, rect_h = 23'd25600;
    logic [4:0]  sides = 5'd3;
    logic [15:0] start_ang = '0;
    logic        use_dist = 1'b0;
    logic [15:0] dist_cells [16];

    bit inside_queue [$];
    int errors = 0;
    int snd_idle = 0;
    int rcv_idle = 0;

    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] dist_val;
        logic [23:0] px;
        logic [23:0] py;
        bit          typed;
        bit          exp_res;
    } t_row;

    t_row rows [$];

    function automatic int unsigned quarter_wave(int unsigned z);
        int unsigned z2, t;
        z2 = (z * z) >> 14;
        t = (SIN_C * z2) >> 14;
        t = SIN_B - t;
        t = (t * z2) >> 14;
        t = SIN_A - t;
        return (z * t) >> 14;
    endfunction

    function automatic longint sine14(int unsigned a);
        int unsigned q, r;
        longint s;
        q = (a >> 14) & 3;
        r = a & 32'h3FFF;
        s = longint'(quarter_wave(q[0] ? QUARTER - r : r));
        return q[1] ? -s : s;
    endfunction

    function automatic bit polygon_inside(logic [23:0] qx, logic [23:0] qy);
        longint vx [16], vy [16];
        longint cx, cy, px, py, d, k, xi, yi, xj, yj, dy, lhs, rhs;
        int unsigned n, m, a, i, j;
        bit odd;
        odd = 1'b0;
        n = sides;
        if (n < 3) n = 3;
        if (n > 16) n = 16;
        m = (rect_w < rect_h) ? rect_w : rect_h;
        cx = 2 * longint'(min_x) + longint'(m);
        cy = 2 * longint'(min_y) + longint'(m);
        px = 2 * longint'($signed(qx));
        py = 2 * longint'($signed(qy));
        for (i = 0; i < n; i++) begin
            a = (start_ang + (i * 65536) / n) & 32'hFFFF;
            d = use_dist ? longint'(dist_cells[i]) : longint'(DIST_ONE);
            k = longint'(m) * d;
            vx[i] = cx + ((k * sine14((a + QUARTER) & 32'hFFFF) + (64'sd1 <<< 27)) >>> 28);
            vy[i] = cy + ((k * sine14(a) + (64'sd1 <<< 27)) >>> 28);
        end
        j = n - 1;
        for (i = 0; i < n; i++) begin
            xi = vx[i]; yi = vy[i]; xj = vx[j]; yj = vy[j];
            if (((yi < py && yj >= py) || (yj < py && yi >= py)) && (xi <= px || xj <= px)) begin
                dy = yj - yi;
                lhs = (py - yi) * (xj - xi);
                rhs = (px - xi) * dy;
                if (dy > 0 ? lhs < rhs : lhs > rhs) odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    // result side
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (inside_queue.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %0d",
                         $realtime, m_axis_tdata[0]);
                errors++;
            end else begin
                if (m_axis_tdata[0] !== inside_queue[0]) begin
                    $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                             $realtime, inside_queue[0], m_axis_tdata[0]);
                    errors++;
                end
                void'(inside_queue.pop_front());
            end
        end
    end

    task automatic send_item(t_row r);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {4'b0, r.py, r.px, r.dist_val, r.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (r.op == OP_TEST)
            inside_queue.push_back(r.typed ? r.exp_res : polygon_inside(r.px, r.py));
        else
            dist_cells[r.slot] = r.dist_val;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (inside_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_X:    min_x = value[23:0];
            REG_MIN_Y:    min_y = value[23:0];
            REG_WIDTH:    rect_w = value[22:0];
            REG_HEIGHT:   rect_h = value[22:0];
            REG_SIDES:    sides = value[4:0];
            REG_START:    start_ang = value[15:0];
            REG_USE_DIST: use_dist = value[0];
            default: ;
        endcase
    endtask

    function automatic t_row make_row(logic op, logic [3:0] slot, logic [15:0] dist_val,
                                      logic [23:0] px, logic [23:0] py, bit typed,
                                      bit exp_res);
        t_row r;
        r.op = op; r.slot = slot; r.dist_val = dist_val; r.px = px; r.py = py;
        r.typed = typed; r.exp_res = exp_res;
        return r;
    endfunction

    function automatic t_row random_row();
        longint m, spread, cx, cy;
        if ($urandom_range(99) < 15)
            return make_row(OP_LOAD, 4'($urandom), 16'($urandom), 24'($urandom),
                            24'($urandom), 0, 0);
        if ($urandom_range(99) < 25)
            return make_row(OP_TEST, 4'($urandom), 16'($urandom), 24'($urandom),
                            24'($urandom), 0, 0);
        // mostly points around the polygon so that edges are crossed both ways
        m = (rect_w < rect_h) ? rect_w : rect_h;
        spread = (m == 0) ? 256 : m;
        cx = longint'(min_x) + m / 2;
        cy = longint'(min_y) + m / 2;
        return make_row(OP_TEST, 4'($urandom), 16'($urandom),
                        24'(cx + longint'($urandom_range(32'(4 * spread))) - 2 * spread),
                        24'(cy + longint'($urandom_range(32'(4 * spread))) - 2 * spread),
                        0, 0);
    endfunction

    initial begin
        int p, k;
        t_row r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset geometry: triangle of radius 50 centred at (50, 50)
        rows.push_back(make_row(OP_TEST, 4'hF, 16'hFFFF, 24'd12800, 24'd12800, 1, 1));
        rows.push_back(make_row(OP_TEST, 4'h0, 16'h0, 24'h7FFFFF, 24'h7FFFFF, 1, 0));
        rows.push_back(make_row(OP_TEST, 4'h0, 16'h0, 24'h800000, 24'h800000, 1, 0));
        rows.push_back(make_row(OP_TEST, 4'h0, 16'h0, 24'h0, 24'h0, 0, 0));
        rows.push_back(make_row(OP_LOAD, 4'd0, 16'h0000, 24'h0, 24'h0, 0, 0));
        rows.push_back(make_row(OP_LOAD, 4'd1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
        for (k = 2; k < 16; k++)
            rows.push_back(make_row(OP_LOAD, 4'(k), 16'(16384 + k * 1500), 24'h0, 24'h0, 0, 0));
        rows.push_back(make_row(OP_TEST, 4'h0, 16'h0, 24'd25600, 24'd12800, 0, 0));
        rows.push_back(make_row(OP_TEST, 4'h0, 16'h0, 24'd12800, 24'd0, 0, 0));
        rows.push_back(make_row(OP_LOAD, 4'd0, 16'd16384, 24'h123456, 24'hABCDEF, 0, 0));
        foreach (rows[i]) send_item(rows[i]);

        for (p = 0; p < 6; p++) begin
            drain();
            repeat (SETTLE) @(posedge i_clk);
            snd_idle = (p < 2) ? 37 : (p < 4) ? 69 : 0;
            rcv_idle = (p < 2) ? 69 : (p < 4) ? 37 : 0;
            case (p)
                1: begin
                    write_reg(REG_MIN_X, 32'hFF800000);
                    write_reg(REG_MIN_Y, 32'h007FFFFF);
                    write_reg(REG_WIDTH, 32'h7FFFFF);
                    write_reg(REG_HEIGHT, 32'h7FFFFF);
                    write_reg(REG_SIDES, 32'd16);
                    write_reg(REG_START, 32'hFFFF);
                    write_reg(REG_USE_DIST, 32'd1);
                end
                2: begin
                    write_reg(REG_WIDTH, 32'd0);
                    write_reg(REG_SIDES, 32'd0);
                    write_reg(REG_START, 32'd0);
                end
                3: begin
                    write_reg(REG_MIN_X, 32'($urandom_range(40000)) - 20000);
                    write_reg(REG_MIN_Y, 32'($urandom_range(40000)) - 20000);
                    write_reg(REG_WIDTH, 32'd6000);
                    write_reg(REG_HEIGHT, 32'd9000);
                    write_reg(REG_SIDES, 32'd31);
                    write_reg(REG_USE_DIST, 32'd0);
                end
                default: begin
                    write_reg(REG_MIN_X, 32'($urandom));
                    write_reg(REG_MIN_Y, 32'($urandom));
                    write_reg(REG_WIDTH, 32'($urandom_range(60000)));
                    write_reg(REG_HEIGHT, 32'($urandom_range(60000)));
                    write_reg(REG_SIDES, 32'($urandom_range(16, 3)));
                    write_reg(REG_START, 32'($urandom));
                    write_reg(REG_USE_DIST, 32'($urandom_range(1)));
                end
            endcase
            for (k = 0; k < 190; k++) begin
                if (p == 1 && k == 60) drain();
                r = random_row();
                send_item(r);
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && inside_queue.size() == 0) begin
            $display("regular_polygon_hit_test verification clean");
        end else begin
            $display("regular_polygon_hit_test verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("regular_polygon_hit_test verification failed");
        $finish;
    end

endmodule
